// ===== rtl/core/sync_frame_deframer_sum16_macros.svh =====
// ----------------------------------------------------------------------------
// sync_frame_deframer_sum16 assertion macros
// shared concurrent assertion forms, empty when synthesis is defined
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_DEFRAMER_SUM16_MACROS_SVH
`define SYNC_FRAME_DEFRAMER_SUM16_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SFD_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`else

`define SFD_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define SFD_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants of the sync frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

    // frame buffer depth in bytes
    localparam int DATA_DEPTH = 64;

    localparam int IDX_W  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int CNT_W  = $clog2(DATA_DEPTH + 1);
    // two banks so the back end can drain one frame while the next fills
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
    localparam int RAM_AW    = IDX_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CFG_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int DLEN_W    = 7;
    localparam int DIDX_W    = 6;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h1F;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hF1;
    localparam logic [CFG_W-1:0]  LIMIT_RESET = 7'd50;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_CKSUM = 2'd1,
        ST_LEN   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ADDR_LO,
        PH_ADDR_HI,
        PH_ID_LO,
        PH_ID_HI,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CK_LO,
        PH_CK_HI
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_OUT
    } bstate_t;

    // one finished frame handed from the parser to the emitter
    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  address;
        logic [WORD_W-1:0]  msg_id;
        logic [CNT_W-1:0]   length;
        logic               has_data;
        logic               bank;
    } job_t;

    // bank release from the emitter
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    // buffer write request from the parser
    typedef struct packed {
        logic               en;
        logic [RAM_AW-1:0]  addr;
        logic [BYTE_W-1:0]  data;
    } ram_wr_t;

endpackage

// ===== rtl/core/sfd_if.sv =====
// ----------------------------------------------------------------------------
// sfd channel interfaces
// byte input, configuration write and result output channels
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    import sfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_cfg_if;
    import sfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_data_length;

    modport source (output valid, output max_data_length, input ready);
    modport sink   (input valid, input max_data_length, output ready);
endinterface

interface sfd_result_if;
    import sfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   frame_address;
    logic [WORD_W-1:0]   message_id;
    logic [DLEN_W-1:0]   data_length;
    logic                has_data;
    logic [DIDX_W-1:0]   data_index;
    logic [BYTE_W-1:0]   data_value;
    logic                last;

    modport source (
        output valid, output status, output frame_address, output message_id,
        output data_length, output has_data, output data_index, output data_value,
        output last, input ready
    );
    modport sink (
        input valid, input status, input frame_address, input message_id,
        input data_length, input has_data, input data_index, input data_value,
        input last, output ready
    );
endinterface

// ===== rtl/core/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_queue
// short frame queue between the parser and the emitter
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfd_pkg::job_t push_job,
    input  logic          pop,
    output sfd_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);
    import sfd_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/sfd_front.sv =====
// ----------------------------------------------------------------------------
// sfd_front
// byte parser: sync hunt, header capture, data buffering, checksum check
// ----------------------------------------------------------------------------
`include "sync_frame_deframer_sum16_macros.svh"

module sfd_front (
    input  logic             clk,
    input  logic             rst_n,
    sfd_byte_if.sink         rx,
    sfd_cfg_if.sink          cfg,
    input  logic             q_full,
    output logic             push,
    output sfd_pkg::job_t    push_job,
    input  sfd_pkg::rel_t    rel,
    output sfd_pkg::ram_wr_t ram_wr
);
    import sfd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              wr_bank_reg, wr_bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [CFG_W-1:0]  limit_reg, limit_next;
    logic [WORD_W-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0] id_reg, id_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] ck_lo_reg, ck_lo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic [WORD_W-1:0] sum_add;
    logic [WORD_W-1:0] len_full;
    logic [WORD_W-1:0] limit_eff;
    logic [WORD_W-1:0] got;
    logic [CNT_W-1:0]  cnt_inc;

    // stall while the queue is full or the bank to fill is still draining
    assign rx.ready  = !q_full && !(phase_reg == PH_DATA && busy_reg[wr_bank_reg]);
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.rx_byte;

    assign sum_add   = sum_reg + {8'h00, b};
    assign len_full  = {b, len_reg[BYTE_W-1:0]};
    assign limit_eff = ({9'd0, limit_reg} > WORD_W'(DATA_DEPTH)) ? WORD_W'(DATA_DEPTH)
                                                                 : {9'd0, limit_reg};
    assign got       = {b, ck_lo_reg};
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        limit_next   = cfg.valid ? cfg.max_data_length : limit_reg;
        addr_next    = addr_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        ck_lo_next   = ck_lo_reg;
        cnt_next     = cnt_reg;
        push         = 1'b0;
        push_job     = '{status: ST_OK, address: addr_reg, msg_id: id_reg,
                         length: '0, has_data: 1'b0, bank: wr_bank_reg};
        ram_wr       = '{en: 1'b0, addr: {wr_bank_reg, cnt_reg[IDX_W-1:0]}, data: b};

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (b == SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        sum_next   = '0;
                        phase_next = PH_ADDR_LO;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_ADDR_LO:
                begin
                    sum_next   = sum_add;
                    addr_next  = {8'h00, b};
                    phase_next = PH_ADDR_HI;
                end
                PH_ADDR_HI:
                begin
                    sum_next   = sum_add;
                    addr_next  = {b, addr_reg[BYTE_W-1:0]};
                    phase_next = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    sum_next   = sum_add;
                    id_next    = {8'h00, b};
                    phase_next = PH_ID_HI;
                end
                PH_ID_HI:
                begin
                    sum_next   = sum_add;
                    id_next    = {b, id_reg[BYTE_W-1:0]};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    sum_next   = sum_add;
                    len_next   = {8'h00, b};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    sum_next = sum_add;
                    len_next = len_full;
                    cnt_next = '0;
                    if (len_full > limit_eff)
                    begin
                        // over the limit: report straight away
                        push            = 1'b1;
                        push_job.status = ST_LEN;
                        phase_next      = PH_SYNC1;
                    end
                    else if (len_full == '0)
                    begin
                        phase_next = PH_CK_LO;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    sum_next  = sum_add;
                    ram_wr.en = 1'b1;
                    cnt_next  = cnt_inc;
                    if ({{(WORD_W-CNT_W){1'b0}}, cnt_inc} >= len_reg)
                    begin
                        phase_next = PH_CK_LO;
                    end
                end
                PH_CK_LO:
                begin
                    ck_lo_next = b;
                    phase_next = PH_CK_HI;
                end
                PH_CK_HI:
                begin
                    push       = 1'b1;
                    phase_next = PH_SYNC1;
                    if (got != sum_reg)
                    begin
                        push_job.status = ST_CKSUM;
                    end
                    else if (len_reg != '0)
                    begin
                        push_job.length   = CNT_W'(len_reg);
                        push_job.has_data = 1'b1;
                        busy_next[wr_bank_reg] = 1'b1;
                        wr_bank_next      = !wr_bank_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
            limit_reg   <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        id_reg    <= id_next;
        len_reg   <= len_next;
        sum_reg   <= sum_next;
        ck_lo_reg <= ck_lo_next;
        cnt_reg   <= cnt_next;
    end

    // never overwrite a bank the emitter still owns
    `SFD_ASSERT_IMPL(a_fill_free_bank, clk, rst_n, ram_wr.en, !busy_reg[wr_bank_reg])
    // a finished frame always finds room in the queue
    `SFD_ASSERT_IMPL(a_push_room, clk, rst_n, push, !q_full)

endmodule

// ===== rtl/core/sfd_back.sv =====
// ----------------------------------------------------------------------------
// sfd_back
// result emitter: one result per buffered byte or one status result
// ----------------------------------------------------------------------------
`include "sync_frame_deframer_sum16_macros.svh"

module sfd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  sfd_pkg::job_t              q_job,
    output logic                       q_pop,
    output logic                       rd_en,
    output logic [sfd_pkg::RAM_AW-1:0] rd_addr,
    input  logic [sfd_pkg::BYTE_W-1:0] rd_data,
    output sfd_pkg::rel_t              rel,
    sfd_result_if.source               result
);
    import sfd_pkg::*;

    bstate_t          st_reg, st_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_inc;
    logic             is_last;

    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign is_last = !job_reg.has_data || (idx_inc == job_reg.length);
    assign rd_addr = {job_reg.bank, idx_reg};

    always_comb
    begin
        st_next  = st_reg;
        job_next = job_reg;
        idx_next = idx_reg;
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        rel      = '{valid: 1'b0, bank: job_reg.bank};

        case (st_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    idx_next = '0;
                    st_next  = q_job.has_data ? B_READ : B_OUT;
                end
            end
            B_READ:
            begin
                rd_en   = 1'b1;
                st_next = B_OUT;
            end
            B_OUT:
            begin
                if (result.ready)
                begin
                    if (is_last)
                    begin
                        rel.valid = job_reg.has_data;
                        st_next   = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        st_next  = B_READ;
                    end
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
    end

    assign result.valid         = (st_reg == B_OUT);
    assign result.status        = job_reg.status;
    assign result.frame_address = job_reg.address;
    assign result.message_id    = job_reg.msg_id;
    assign result.data_length   = DLEN_W'(job_reg.length);
    assign result.has_data      = job_reg.has_data;
    assign result.data_index    = DIDX_W'(idx_reg);
    assign result.data_value    = job_reg.has_data ? rd_data : '0;
    assign result.last          = is_last;

    // byte results stay inside the frame
    `SFD_ASSERT_IMPL(a_index_in_frame, clk, rst_n, result.valid && result.has_data,
        {1'b0, result.data_index} < result.data_length)
    // error results are single and carry no byte
    `SFD_ASSERT_IMPL(a_error_single, clk, rst_n, result.valid && result.status != ST_OK,
        !result.has_data && result.last)
    // a waiting frame is always taken up
    `SFD_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, st_reg == B_IDLE && !q_empty,
        st_reg != B_IDLE)

endmodule

// ===== rtl/core/sync_frame_deframer_sum16.sv =====
// ----------------------------------------------------------------------------
// sync_frame_deframer_sum16
// sync-framed byte stream parser with 16-bit byte-sum checksum
// ----------------------------------------------------------------------------
// result path: an error or an empty good frame goes through the queue and the
//   emitter state register; a frame with data adds a registered buffer read
// throughput: one byte per cycle while the queue has room and the bank to fill
//   is free; byte results never leave back to back (registered buffer read)
// reset: rst_n clears parser, queue and emitter control and loads the limit
//   with 50; the frame buffer is not cleared and no clearing pass runs
// ----------------------------------------------------------------------------
module sync_frame_deframer_sum16 (
    input  logic         clk,
    input  logic         rst_n,
    sfd_byte_if.sink     rx,
    sfd_cfg_if.sink      cfg,
    sfd_result_if.source result
);
    import sfd_pkg::*;

    // parser to queue
    logic    push;
    job_t    push_job;
    logic    q_full;

    // queue to emitter
    logic    pop;
    job_t    pop_job;
    logic    q_empty;

    // emitter hands a drained bank back to the parser
    rel_t    rel;

    // frame buffer ports
    ram_wr_t           ram_wr;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // front: hunts for sync, takes the header, fills one buffer bank and
    // checks the checksum; every finished frame becomes one queue request
    sfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job),
        .rel      (rel),
        .ram_wr   (ram_wr)
    );

    // two-deep queue so parsing and result emission stall independently
    sfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // frame buffer, two banks of one frame each, ping-ponged by the parser
    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // back: turns each queued frame into its results
    sfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .q_pop   (pop),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rel     (rel),
        .result  (result)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// byte-level self-checking bench for the sync frame deframer: frames are built
// with random headers, data and checksums, every received byte is run through
// a local parser model and each result request is compared field by field
// ----------------------------------------------------------------------------
module tb_top;
    import sfd_pkg::*;

    // quiet cycles before the run is declared hung; longest legal gap is the
    // long result hold-off below
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_GAP       = 11;

    // one result request as the block should present it
    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   frame_address;
        logic [WORD_W-1:0]   message_id;
        logic [DLEN_W-1:0]   data_length;
        logic                has_data;
        logic [DIDX_W-1:0]   data_index;
        logic [BYTE_W-1:0]   data_value;
        logic                last;
    } frame_result_t;

    // one directed frame; want_count and want_status are read straight off
    // the frame format
    typedef struct {
        logic [BYTE_W-1:0] sync2;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] ck_delta;
        int                want_count;
        status_t           want_status;
    } frame_row_t;

    logic clk;
    logic rst_n;

    sfd_byte_if   rx_ch ();
    sfd_cfg_if    cfg_ch ();
    sfd_result_if res_ch ();

    sync_frame_deframer_sum16 u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // ------------------------------------------------------------------
    // local parser model state, mirrors the block from reset
    // ------------------------------------------------------------------
    phase_t             rx_phase = PH_SYNC1;
    logic [WORD_W-1:0]  held_addr = '0;
    logic [WORD_W-1:0]  held_id = '0;
    logic [WORD_W-1:0]  held_len = '0;
    logic [CFG_W-1:0]   byte_cnt = '0;
    logic [WORD_W-1:0]  run_sum = '0;
    logic [BYTE_W-1:0]  ck_low = '0;
    logic [BYTE_W-1:0]  frame_store [DATA_DEPTH];
    logic [CFG_W-1:0]   limit_reg = LIMIT_RESET;

    frame_result_t      pending_results [$];
    status_t            last_status = ST_OK;

    int results_predicted = 0;
    int results_checked = 0;
    int error_count = 0;
    int frame_bytes_sent = 0;
    int noise_bytes_sent = 0;
    int good_frames = 0;
    int cksum_frames = 0;
    int len_frames = 0;

    // handshake pacing of both sides
    logic source_steady = 1'b0;
    logic sink_steady = 1'b0;
    logic hold_request = 1'b0;

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic int effective_limit();
        // limit above the buffer depth is clamped to the depth
        return (limit_reg > DATA_DEPTH) ? DATA_DEPTH : int'(limit_reg);
    endfunction

    function automatic void expect_result(status_t st, logic [DLEN_W-1:0] dlen,
                                          logic has, logic [DIDX_W-1:0] idx,
                                          logic [BYTE_W-1:0] val, logic last);
        frame_result_t r;
        r.status        = st;
        r.frame_address = held_addr;
        r.message_id    = held_id;
        r.data_length   = dlen;
        r.has_data      = has;
        r.data_index    = idx;
        r.data_value    = val;
        r.last          = last;
        pending_results.push_back(r);
        results_predicted++;
        last_status = st;
    endfunction

    // advance the parser model by one accepted byte and queue what it yields
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        int lim;
        logic [WORD_W-1:0] got;
        // header and data bytes feed the checksum
        if (rx_phase >= PH_ADDR_LO && rx_phase <= PH_DATA)
            run_sum = run_sum + {8'h00, b};
        case (rx_phase)
            PH_SYNC1:
            begin
                if (b == SYNC_FIRST)
                    rx_phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                // a wrong second sync byte is dropped, even a repeated 0x1F
                if (b == SYNC_SECOND)
                begin
                    run_sum = '0;
                    rx_phase = PH_ADDR_LO;
                end
                else
                    rx_phase = PH_SYNC1;
            end
            PH_ADDR_LO:
            begin
                held_addr = {8'h00, b};
                rx_phase = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                held_addr[15:8] = b;
                rx_phase = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                held_id = {8'h00, b};
                rx_phase = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                held_id[15:8] = b;
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                held_len = {8'h00, b};
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                held_len[15:8] = b;
                lim = effective_limit();
                byte_cnt = '0;
                // whole 16-bit length against the limit, error at once
                if (held_len > lim)
                begin
                    rx_phase = PH_SYNC1;
                    expect_result(ST_LEN, '0, 1'b0, '0, '0, 1'b1);
                    len_frames++;
                end
                else
                    rx_phase = (held_len == 0) ? PH_CK_LO : PH_DATA;
            end
            PH_DATA:
            begin
                if (byte_cnt < DATA_DEPTH)
                    frame_store[byte_cnt[IDX_W-1:0]] = b;
                byte_cnt++;
                if (byte_cnt >= held_len)
                    rx_phase = PH_CK_LO;
            end
            PH_CK_LO:
            begin
                ck_low = b;
                rx_phase = PH_CK_HI;
            end
            PH_CK_HI:
            begin
                got = {b, ck_low};
                rx_phase = PH_SYNC1;
                if (got != run_sum)
                begin
                    expect_result(ST_CKSUM, '0, 1'b0, '0, '0, 1'b1);
                    cksum_frames++;
                end
                else if (held_len == 0)
                begin
                    // good frame without data still gives one result
                    expect_result(ST_OK, '0, 1'b0, '0, '0, 1'b1);
                    good_frames++;
                end
                else
                begin
                    for (int i = 0; i < held_len && i < DATA_DEPTH; i++)
                        expect_result(ST_OK, held_len[DLEN_W-1:0], 1'b1, i[DIDX_W-1:0],
                                      frame_store[i[IDX_W-1:0]], (i + 1 == held_len));
                    good_frames++;
                end
            end
            default:
                rx_phase = PH_SYNC1;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // byte source: random gap, then hold the request until it is taken
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        parse_rx_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return SYNC_FIRST;
            3:       return SYNC_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly short frames, now and then empty or at the limit
    function automatic logic [WORD_W-1:0] pick_len(input int eff);
        int r;
        if (eff == 0)
            return '0;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'(eff);
        if (r == 1)
            return '0;
        return 16'($urandom_range(1, (eff < 8) ? eff : 8));
    endfunction

    // build a frame: sync pair, header, data and checksum; stops after a bad
    // second sync byte, and after the header when the length is over the limit
    task automatic send_frame(input logic [BYTE_W-1:0] sync2,
                              input logic [WORD_W-1:0] addr, input logic [WORD_W-1:0] id,
                              input logic [WORD_W-1:0] len,
                              input logic [WORD_W-1:0] ck_delta);
        logic [BYTE_W-1:0] frame_q [$];
        logic [BYTE_W-1:0] b;
        logic [WORD_W-1:0] ck;
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(sync2);
        if (sync2 == SYNC_SECOND)
        begin
            frame_q.push_back(addr[7:0]);
            frame_q.push_back(addr[15:8]);
            frame_q.push_back(id[7:0]);
            frame_q.push_back(id[15:8]);
            frame_q.push_back(len[7:0]);
            frame_q.push_back(len[15:8]);
            ck = {8'h00, addr[7:0]} + {8'h00, addr[15:8]} + {8'h00, id[7:0]}
                 + {8'h00, id[15:8]} + {8'h00, len[7:0]} + {8'h00, len[15:8]};
            if (len <= effective_limit())
            begin
                for (int i = 0; i < len; i++)
                begin
                    b = pick_byte();
                    frame_q.push_back(b);
                    ck = ck + {8'h00, b};
                end
                ck = ck + ck_delta;
                frame_q.push_back(ck[7:0]);
                frame_q.push_back(ck[15:8]);
            end
        end
        foreach (frame_q[i])
            send_byte(frame_q[i]);
        frame_bytes_sent += frame_q.size();
    endtask

    // sender pause: drop the request and wait for every result to come out
    task automatic wait_results_done();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // bring the parser back to hunting, drain and let the pipeline settle
    task automatic quiesce();
        while (rx_phase != PH_SYNC1)
        begin
            send_byte(8'h00);
            noise_bytes_sent++;
        end
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.max_data_length <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        limit_reg = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random mix: mostly well-formed frames, some broken ones and line noise
    task automatic random_frames(input int target);
        int stop_at;
        int kind;
        int eff;
        int n;
        logic [WORD_W-1:0] len;
        logic [BYTE_W-1:0] bad;
        stop_at = frame_bytes_sent + target;
        while (frame_bytes_sent < stop_at)
        begin
            eff = effective_limit();
            kind = $urandom_range(0, 99);
            source_steady = ($urandom_range(0, 3) == 0);
            if (kind < 70)
                send_frame(SYNC_SECOND, pick_word(), pick_word(), pick_len(eff), '0);
            else if (kind < 80)
                send_frame(SYNC_SECOND, pick_word(), pick_word(), pick_len(eff),
                           16'($urandom_range(1, 65535)));
            else if (kind < 88)
            begin
                // just over the limit, or anywhere above it incl. high byte set
                len = ($urandom_range(0, 1) == 1) ? 16'(eff + 1)
                                                  : 16'($urandom_range(eff + 1, 65535));
                send_frame(SYNC_SECOND, pick_word(), pick_word(), len, '0);
            end
            else if (kind < 94)
            begin
                bad = 8'($urandom_range(0, 254));
                if (bad >= SYNC_SECOND)
                    bad++;
                send_frame(($urandom_range(0, 1) == 1) ? SYNC_FIRST : bad,
                           '0, '0, '0, '0);
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_byte(pick_byte());
                noise_bytes_sent += n;
            end
            if ($urandom_range(0, 9) == 0)
                wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // result sink: random stall per result request, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
                gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
            // switch between stretches with and without stalls
            if ($urandom_range(0, 15) == 0)
                sink_steady = ~sink_steady;
        end
    end

    // ------------------------------------------------------------------
    // result check: each accepted request against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result request with nothing expected: status %0d addr %0h",
                       res_ch.status, res_ch.frame_address);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, res_ch.status);
                compare_field("frame_address", want.frame_address, res_ch.frame_address);
                compare_field("message_id", want.message_id, res_ch.message_id);
                compare_field("data_length", want.data_length, res_ch.data_length);
                compare_field("has_data", want.has_data, res_ch.has_data);
                compare_field("data_index", want.data_index, res_ch.data_index);
                compare_field("data_value", want.data_value, res_ch.data_value);
                compare_field("last", want.last, res_ch.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any request taken on any channel
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request taken for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        frame_row_t       directed_rows [4];
        logic [CFG_W-1:0] phase_limit [5];
        int               phase_bytes [5];
        int               prev_count;

        rst_n                  = 1'b0;
        rx_ch.valid            = 1'b0;
        rx_ch.rx_byte          = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.max_data_length = '0;

        // bad second sync (repeated 0x1F), all-ones header far over the
        // limit, empty good frame, empty frame with a wrong checksum
        directed_rows = '{
            '{SYNC_FIRST,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, ST_OK},
            '{SYNC_SECOND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1, ST_LEN},
            '{SYNC_SECOND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, ST_OK},
            '{SYNC_SECOND, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 1, ST_CKSUM}
        };
        // zero limit, clamp above depth, depth itself, random, smallest nonzero
        phase_limit = '{7'd0, 7'd127, 7'd64, 7'($urandom_range(2, 63)), 7'd1};
        phase_bytes = '{20, 10, 40, 30, 20};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames with the reset limit
        foreach (directed_rows[i])
        begin
            prev_count = results_predicted;
            send_frame(directed_rows[i].sync2, directed_rows[i].addr, directed_rows[i].id,
                       directed_rows[i].len, directed_rows[i].ck_delta);
            compare_field("result count", directed_rows[i].want_count,
                          results_predicted - prev_count);
            if (directed_rows[i].want_count != 0)
                compare_field("status", directed_rows[i].want_status, last_status);
        end

        // random frames with the reset limit
        random_frames(40);

        foreach (phase_limit[p])
        begin
            quiesce();
            write_limit(phase_limit[p]);
            if (phase_limit[p] > DATA_DEPTH)
            begin
                // sink holds off after the first result while back-to-back
                // frames pile up behind it, starting with a full-depth one
                hold_request = 1'b1;
                source_steady = 1'b1;
                send_frame(SYNC_SECOND, pick_word(), pick_word(),
                           16'(effective_limit()), '0);
                repeat (3)
                    send_frame(SYNC_SECOND, pick_word(), pick_word(),
                               16'($urandom_range(8, 24)), '0);
            end
            random_frames(phase_bytes[p]);
        end

        quiesce();
        repeat (20) @(posedge clk);

        $display("covered %0d frame bytes and %0d noise bytes over six limit settings",
                 frame_bytes_sent, noise_bytes_sent);
        $display("checked %0d results: %0d good, %0d checksum and %0d length errors",
                 results_checked, good_frames, cksum_frames, len_frames);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
